// ----- design/assert_macros.svh -----
// Assertion macros shared by the call graph arc counter modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define ASSERT_IMPL(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// Check that cond holds in the cycle after trig.
`define ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

// ----- design/cgac_pkg.sv -----
// Package for the call graph arc counter: widths, table entry layout,
// controller states and the command/status structs. No dependencies.
package cgac_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SYM_W       = 10;
    localparam int FREE_W      = ((IDX_W > SYM_W) ? IDX_W : SYM_W) + 1;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int KEY_W       = ADDR_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [KEY_W-1:0] OUTSIDE_KEY = {1'b1, {ADDR_W{1'b0}}};
    localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] STEP_LAST   = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_PC      = 2'd0,
        CFG_HIGH_PC     = 2'd1,
        CFG_NUM_SYMBOLS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [KEY_W-1:0]  key;
        logic              valid;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  link;
    } arc_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LINK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACT_REPORT,
        ACT_FOLLOW,
        ACT_LINK
    } act_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd;
        logic eval;
        logic link_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        act_t act;
        logic out_free;
    } status_t;

endpackage

// ----- design/call_graph_arc_counter_top.sv -----
// Flow: after acceptance each arc entry visited is read and evaluated, a new arc adds a
// link write, then out_valid is loaded; a stalled output holds the controller.
// Calls are taken one at a time; each walks the single-port arc table (read, then write).
// Reset: asynchronous, active low; a clearing pass over all TABLE_DEPTH (1024) entries
// then zeroes the arc table, with in_ready low; config writes are taken throughout.
module call_graph_arc_counter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cgac_pkg::SYM_W-1:0]      callee_index,
    input  logic                            caller_known,
    input  logic [cgac_pkg::ADDR_W-1:0]     caller_addr,
    input  logic [cgac_pkg::ADDR_W-1:0]     callee_addr,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cgac_pkg::ADDR_W-1:0]     target_addr,
    output logic [cgac_pkg::CNT_W-1:0]      call_count,
    output logic                            pool_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cgac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cgac_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cgac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cgac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .callee_index (callee_index),
        .caller_known (caller_known),
        .caller_addr  (caller_addr),
        .callee_addr  (callee_addr),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .target_addr  (target_addr),
        .call_count   (call_count),
        .pool_full    (pool_full)
    );

endmodule

// ----- design/cgac_ctrl.sv -----
// Controller state machine of the call graph arc counter.
// Depends on cgac_pkg and assert_macros.svh; drives cgac_dp by commands.
`include "assert_macros.svh"

module cgac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cgac_pkg::status_t status,
    output cgac_pkg::cmd_t    cmd
);
    import cgac_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                case (status.act)
                    ACT_FOLLOW: state_next = ST_READ;
                    ACT_LINK:   state_next = ST_LINK;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_LINK:
            begin
                cmd.link_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_load_free, cmd.out_load, status.out_free)
    `ASSERT_NEXT(a_accept_read, in_valid && in_ready, state_reg == ST_READ)
    `ASSERT_IMPL(a_ready_idle, in_ready, state_reg == ST_IDLE)

endmodule

// ----- design/cgac_dp.sv -----
// Datapath of the call graph arc counter: config registers, arc table
// memory, chain walk decode, free pool pointer and output register.
// Depends on cgac_pkg and assert_macros.svh; sequenced by cgac_ctrl.
`include "assert_macros.svh"

module cgac_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [cgac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cgac_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  cgac_pkg::cmd_t                    cmd,
    output cgac_pkg::status_t                 status,
    input  logic [cgac_pkg::SYM_W-1:0]        callee_index,
    input  logic                              caller_known,
    input  logic [cgac_pkg::ADDR_W-1:0]       caller_addr,
    input  logic [cgac_pkg::ADDR_W-1:0]       callee_addr,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [cgac_pkg::ADDR_W-1:0]       target_addr,
    output logic [cgac_pkg::CNT_W-1:0]        call_count,
    output logic                              pool_full
);
    import cgac_pkg::*;

    arc_entry_t        arc_mem [TABLE_DEPTH];

    logic [ADDR_W-1:0] low_pc_reg;
    logic [ADDR_W-1:0] high_pc_reg;
    logic [FREE_W-1:0] free_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic              first_reg;
    logic [IDX_W-1:0]  steps_reg;
    logic              known_reg;
    logic [ADDR_W-1:0] caller_reg;
    logic [ADDR_W-1:0] callee_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    arc_entry_t        rd_data_reg;
    arc_entry_t        entry_reg;
    arc_entry_t        entry_next;
    logic              full_reg;
    logic              full_next;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] target_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              pool_full_reg;

    act_t              act;
    logic              eval_wr;
    arc_entry_t        eval_data;
    logic [CNT_W-1:0]  count_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    arc_entry_t        wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pc_reg  <= '0;
            high_pc_reg <= '0;
            free_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LOW_PC:      low_pc_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_HIGH_PC:     high_pc_reg <= cfg_data[ADDR_W-1:0];
                    CFG_NUM_SYMBOLS: free_reg    <= FREE_W'(cfg_data[SYM_W-1:0]);
                    default:         ;
                endcase
            end
            if (cmd.link_wr)
            begin
                free_reg <= free_reg + FREE_W'(1);
            end
        end
    end

    // key of the caller: offset inside the text region, else the shared key
    always_comb
    begin
        if (caller_reg > high_pc_reg || caller_reg < low_pc_reg)
        begin
            key_next = OUTSIDE_KEY;
        end
        else
        begin
            key_next = {1'b0, caller_reg - low_pc_reg};
        end
    end

    always_comb
    begin
        act        = ACT_REPORT;
        eval_wr    = 1'b0;
        eval_data  = rd_data_reg;
        entry_next = rd_data_reg;
        full_next  = 1'b0;
        count_inc  = (rd_data_reg.count == COUNT_MAX) ? rd_data_reg.count
                                                      : rd_data_reg.count + CNT_W'(1);
        if (first_reg && rd_data_reg.offset == '0)
        begin
            eval_data.offset = callee_reg - low_pc_reg;
            eval_data.key    = key_reg;
            eval_data.valid  = known_reg;
            if (known_reg)
            begin
                eval_data.count = CNT_W'(1);
            end
            eval_wr    = 1'b1;
            entry_next = eval_data;
        end
        else if (first_reg && !known_reg)
        begin
            act = ACT_REPORT;
        end
        else if (!rd_data_reg.valid)
        begin
            eval_data.key   = key_reg;
            eval_data.valid = 1'b1;
            eval_data.count = CNT_W'(1);
            eval_wr         = 1'b1;
            entry_next      = eval_data;
        end
        else if (rd_data_reg.key == key_reg)
        begin
            eval_data.count = count_inc;
            eval_wr         = 1'b1;
            entry_next      = eval_data;
        end
        else if (rd_data_reg.link != '0)
        begin
            if (steps_reg != STEP_LAST)
            begin
                act = ACT_FOLLOW;
            end
        end
        else if (free_reg >= FREE_W'(TABLE_DEPTH))
        begin
            full_next = 1'b1;
        end
        else
        begin
            act              = ACT_LINK;
            eval_wr          = 1'b1;
            eval_data.link   = free_reg[IDX_W-1:0];
            entry_next.key   = key_reg;
            entry_next.valid = 1'b1;
            entry_next.count = CNT_W'(1);
            entry_next.link  = '0;
        end
    end

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else if (cmd.link_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = free_reg[IDX_W-1:0];
            wr_data = entry_reg;
        end
        else
        begin
            wr_en   = cmd.eval && eval_wr;
            wr_addr = cur_reg;
            wr_data = eval_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            arc_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= arc_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.accept)
            begin
                first_reg <= 1'b1;
            end
            else if (cmd.eval && act == ACT_FOLLOW)
            begin
                first_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_reg    <= IDX_W'(callee_index);
            steps_reg  <= '0;
            known_reg  <= caller_known;
            caller_reg <= caller_addr;
            callee_reg <= callee_addr;
        end
        if (cmd.rd)
        begin
            key_reg <= key_next;
        end
        if (cmd.eval)
        begin
            if (act == ACT_FOLLOW)
            begin
                cur_reg   <= rd_data_reg.link;
                steps_reg <= steps_reg + IDX_W'(1);
            end
            else
            begin
                entry_reg <= entry_next;
                full_reg  <= full_next;
            end
        end
        if (cmd.out_load)
        begin
            target_reg    <= entry_reg.offset + low_pc_reg;
            count_reg     <= full_reg ? '0 : entry_reg.count;
            pool_full_reg <= full_reg;
        end
    end

    assign status.clr_last = (clr_reg == STEP_LAST);
    assign status.act      = act;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign target_addr = target_reg;
    assign call_count  = count_reg;
    assign pool_full   = pool_full_reg;

    `ASSERT_IMPL(a_link_room, cmd.link_wr, free_reg < FREE_W'(TABLE_DEPTH))
    `ASSERT_NEXT(a_follow_link, cmd.eval && act == ACT_FOLLOW, cur_reg != '0 && !first_reg)
    `ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_reg)

endmodule

// ----- tb/call_graph_arc_counter_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for call_graph_arc_counter_top: directed and random calls,
// each response checked against an in-bench arc table predictor.
// Depends on cgac_pkg and the call graph arc counter RTL.
module call_graph_arc_counter_top_tb;
    import cgac_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] target;
        logic [CNT_W-1:0]  count;
        logic              full;
    } arc_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [SYM_W-1:0]      callee_index;
    logic                  caller_known;
    logic [ADDR_W-1:0]     caller_addr;
    logic [ADDR_W-1:0]     callee_addr;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ADDR_W-1:0]     target_addr;
    logic [CNT_W-1:0]      call_count;
    logic                  pool_full;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [ADDR_W-1:0] tbl_offset [TABLE_DEPTH];
    logic [KEY_W-1:0]  tbl_key    [TABLE_DEPTH];
    logic              tbl_known  [TABLE_DEPTH];
    logic [CNT_W-1:0]  tbl_count  [TABLE_DEPTH];
    logic [IDX_W-1:0]  tbl_link   [TABLE_DEPTH];
    logic [FREE_W-1:0] pool_next;
    logic [ADDR_W-1:0] pc_low;
    logic [ADDR_W-1:0] pc_high;

    arc_report_t       reports_due [$];
    arc_report_t       due;
    bit                throttle;
    int unsigned       hold_cnt;
    int unsigned       fails;
    int unsigned       calls_sent;
    int unsigned       reports_seen;
    int unsigned       full_seen;
    int unsigned       settings_used;

    call_graph_arc_counter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .callee_index (callee_index),
        .caller_known (caller_known),
        .caller_addr  (caller_addr),
        .callee_addr  (callee_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .target_addr  (target_addr),
        .call_count   (call_count),
        .pool_full    (pool_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (!throttle || r < 55)
            len = 0;
        else if (r < 90)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(4, 40);
        return len;
    endfunction

    // Find or create the arc for one call and return what the block must report.
    function automatic arc_report_t count_call(input logic [SYM_W-1:0] idx,
                                               input logic known,
                                               input logic [ADDR_W-1:0] caller,
                                               input logic [ADDR_W-1:0] callee);
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] n;
        logic [KEY_W-1:0] key;
        logic             full;
        logic             done;
        int unsigned      steps;
        arc_report_t      rep;
        cur   = IDX_W'(idx);
        full  = 1'b0;
        done  = 1'b0;
        steps = 0;
        if (caller > pc_high || caller < pc_low)
            key = OUTSIDE_KEY;
        else
            key = {1'b0, caller - pc_low};
        if (tbl_offset[cur] == '0)
        begin
            tbl_offset[cur] = callee - pc_low;
            tbl_key[cur]    = key;
            tbl_known[cur]  = known;
            if (known)
                tbl_count[cur] = 1;
        end
        else if (known)
        begin
            while (!done)
            begin
                if (!tbl_known[cur])
                begin
                    tbl_key[cur]   = key;
                    tbl_known[cur] = 1'b1;
                    tbl_count[cur] = 1;
                    done = 1'b1;
                end
                else if (tbl_key[cur] == key)
                begin
                    if (tbl_count[cur] != COUNT_MAX)
                        tbl_count[cur] = tbl_count[cur] + 1;
                    done = 1'b1;
                end
                else if (tbl_link[cur] != '0)
                begin
                    steps++;
                    if (steps >= TABLE_DEPTH)
                        done = 1'b1;
                    else
                        cur = tbl_link[cur];
                end
                else if (pool_next >= TABLE_DEPTH)
                begin
                    full = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    n = pool_next[IDX_W-1:0];
                    tbl_link[cur]   = n;
                    tbl_offset[n]   = tbl_offset[cur];
                    tbl_key[n]      = key;
                    tbl_known[n]    = 1'b1;
                    tbl_count[n]    = 1;
                    tbl_link[n]     = '0;
                    pool_next       = pool_next + FREE_W'(1);
                    cur  = n;
                    done = 1'b1;
                end
            end
        end
        rep.target = tbl_offset[cur] + pc_low;
        rep.count  = full ? '0 : tbl_count[cur];
        rep.full   = full;
        return rep;
    endfunction

    task automatic issue_call(input logic [SYM_W-1:0] idx, input logic known,
                              input logic [ADDR_W-1:0] caller,
                              input logic [ADDR_W-1:0] callee);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        callee_index <= idx;
        caller_known <= known;
        caller_addr  <= caller;
        callee_addr  <= callee;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reports_due.push_back(count_call(idx, known, caller, callee));
        calls_sent++;
    endtask

    // Drop the call channel and wait until every response has come back.
    task automatic settle();
        int unsigned n;
        in_valid <= 1'b0;
        n = 0;
        while (reports_due.size() != 0 && n < 50000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOW_PC:  pc_low  = val;
            CFG_HIGH_PC: pc_high = val;
            CFG_NUM_SYMBOLS: pool_next = FREE_W'(val[SYM_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic program_region(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] high,
                                  input logic [SYM_W-1:0] nsym);
        settle();
        write_reg(CFG_LOW_PC, low);
        write_reg(CFG_HIGH_PC, high);
        write_reg(CFG_NUM_SYMBOLS, CFG_DATA_W'(nsym));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_state();
        issue_call(10'd0, 1'b1, 32'h0, 32'h0);
        issue_call(10'd0, 1'b0, 32'hFFFF_FFFF, 32'h10);
        issue_call(10'd0, 1'b1, 32'h0, 32'h20);
        issue_call(10'd0, 1'b1, 32'h5, 32'h30);
        issue_call(10'd1023, 1'b1, 32'h0, 32'hFFFF_FFFF);
    endtask

    task automatic test_region_edges();
        program_region(32'h1000, 32'h1FFF, 10'd16);
        issue_call(10'd3, 1'b1, 32'h1000, 32'h1234);
        issue_call(10'd3, 1'b1, 32'h1FFF, 32'h1234);
        issue_call(10'd3, 1'b1, 32'h0FFF, 32'h1234);
        issue_call(10'd3, 1'b1, 32'h2000, 32'h1234);
        issue_call(10'd3, 1'b1, 32'h1000, 32'h1234);
        issue_call(10'd3, 1'b0, 32'h0, 32'h5555);
        issue_call(10'd17, 1'b1, 32'h1800, 32'h1300);
        issue_call(10'd0, 1'b1, 32'hFFFF_FFFF, 32'h1000);
        issue_call(10'd0, 1'b1, 32'h1004, 32'h2000);
    endtask

    task automatic test_pool_exhausted();
        program_region(32'h0, 32'hFFFF_FFFF, 10'd1023);
        issue_call(10'd40, 1'b1, 32'h100, 32'h500);
        issue_call(10'd40, 1'b1, 32'h200, 32'h500);
        issue_call(10'd40, 1'b1, 32'h300, 32'h500);
        issue_call(10'd40, 1'b1, 32'h200, 32'h500);
    endtask

    task automatic test_inverted_range();
        program_region(32'hFFFF_FFFF, 32'h0, 10'd512);
        issue_call(10'd600, 1'b1, 32'h0, 32'h10);
        issue_call(10'd600, 1'b1, 32'hFFFF_FFFF, 32'h10);
        issue_call(10'd600, 1'b0, 32'h8000_0000, 32'h10);
        issue_call(10'd1023, 1'b1, 32'h1234_5678, 32'h10);
    endtask

    // Most calls hit a few hot heads from a few hot callers so chains grow and repeat.
    task automatic run_random_phase(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] high,
                                    input logic [SYM_W-1:0] nsym, input int unsigned calls);
        logic [SYM_W-1:0]  hot_idx    [8];
        logic [ADDR_W-1:0] hot_caller [12];
        logic [SYM_W-1:0]  idx;
        logic              known;
        logic [ADDR_W-1:0] caller;
        logic [ADDR_W-1:0] callee;
        int unsigned       r;
        int                i;
        program_region(low, high, nsym);
        hot_idx[0] = '0;
        hot_idx[1] = '1;
        hot_idx[2] = nsym;
        for (i = 3; i < 8; i++)
            hot_idx[i] = SYM_W'($urandom_range(0, 1023));
        for (i = 0; i < 12; i++)
            hot_caller[i] = low + 4 * $urandom_range(0, 31);
        hot_caller[0] = low;
        hot_caller[1] = high;
        repeat (calls)
        begin
            r = $urandom_range(0, 99);
            idx = (r < 90) ? hot_idx[$urandom_range(0, 7)] : SYM_W'($urandom());
            known = ($urandom_range(0, 99) < 85);
            r = $urandom_range(0, 99);
            if (r < 70)
                caller = hot_caller[$urandom_range(0, 11)];
            else if (r < 80)
                caller = low - 1;
            else if (r < 85)
                caller = high + 1;
            else
                caller = $urandom();
            r = $urandom_range(0, 99);
            if (r < 10)
                callee = low;
            else if (r < 20)
                callee = $urandom();
            else
                callee = low + $urandom_range(1, 16'hFFFF);
            issue_call(idx, known, caller, callee);
        end
    endtask

    task automatic test_random_calls();
        logic [ADDR_W-1:0] base;
        throttle = 1'b1;
        run_random_phase(32'h0040_0000, 32'h0040_FFFF, 10'd64, 100);
        throttle = 1'b0;
        run_random_phase(32'h0, 32'hFFFF_FFFF, 10'd0, 100);
        throttle = 1'b1;
        run_random_phase(32'hFFFF_F000, 32'hFFFF_FFFF, 10'd1023, 100);
        run_random_phase(32'h8000_0000, 32'h7FFF_FFFF, 10'd512, 100);
        base = $urandom();
        throttle = 1'b0;
        run_random_phase(base, base + $urandom_range(0, 4095),
                         SYM_W'($urandom_range(0, 1023)), 100);
        throttle = 1'b1;
        run_random_phase(32'h1000, 32'h1000, 10'd1000, 100);
        run_random_phase($urandom(), $urandom(), SYM_W'($urandom_range(0, 1023)), 100);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            reports_seen++;
            if (pool_full)
                full_seen++;
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected response, target_addr %h call_count %0d pool_full %b",
                         $time, target_addr, call_count, pool_full);
                fails++;
            end
            else
            begin
                due = reports_due.pop_front();
                if (target_addr !== due.target)
                begin
                    $display("%0t: target_addr expected %h actual %h",
                             $time, due.target, target_addr);
                    fails++;
                end
                if (call_count !== due.count)
                begin
                    $display("%0t: call_count expected %0d actual %0d",
                             $time, due.count, call_count);
                    fails++;
                end
                if (pool_full !== due.full)
                begin
                    $display("%0t: pool_full expected %b actual %b",
                             $time, due.full, pool_full);
                    fails++;
                end
            end
        end
        if (hold_cnt != 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (throttle && $urandom_range(0, 3) == 0)
        begin
            hold_cnt  <= pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #(200_000_000);
        $display("%0t: run timed out", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        callee_index = '0;
        caller_known = 1'b0;
        caller_addr  = '0;
        callee_addr  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LOW_PC;
        cfg_data     = '0;
        fails        = 0;
        calls_sent   = 0;
        reports_seen = 0;
        full_seen    = 0;
        settings_used = 0;
        throttle     = 1'b1;
        pc_low       = '0;
        pc_high      = '0;
        pool_next    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_offset[i] = '0;
            tbl_key[i]    = '0;
            tbl_known[i]  = 1'b0;
            tbl_count[i]  = '0;
            tbl_link[i]   = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_region_edges();
        test_pool_exhausted();
        test_inverted_range();
        test_random_calls();

        settle();
        repeat (16) @(posedge clk);
        if (reports_due.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, reports_due.size());
            fails += reports_due.size();
        end
        $display("Sent %0d calls across %0d region settings, checked %0d responses",
                 calls_sent, settings_used + 1, reports_seen);
        $display("%0d responses reported an exhausted arc pool, %0d mismatches",
                 full_seen, fails);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
